[rtl/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg: shared definitions for the ultrasonic echo ranger
// Widths, timing constants, status codes, register indexes and the result
// bundle passed from the ranging core to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned DIST_W     = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned PRE_LOW_TICKS      = 2;
    localparam int unsigned TRIGGER_HIGH_TICKS = 15;

    // Centimetre conversion: x / 58 == (x >> 1) / 29, and the divide by 29
    // is a multiply by a rounded-up reciprocal. The error of the reciprocal
    // is small enough to stay exact for any 16-bit operand.
    localparam int unsigned CM_DIVISOR  = 58;
    localparam int unsigned CM_HALF     = CM_DIVISOR / 2;
    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned CM_RECIP    = ((1 << RECIP_SHIFT) + CM_HALF - 1) / CM_HALF;
    localparam int unsigned QUOT_W      = 12;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd30000;
    localparam logic [DIST_W-1:0]    MAX_DIST_RESET = 11'd400;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd1;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_VALID   = 3'd1,
        ST_NORISE  = 3'd2,
        ST_TOOLONG = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy;
        logic              done;
        status_t           status;
        logic [DIST_W-1:0] distance_cm;
    } res_t;

endpackage

`default_nettype wire

[rtl/uer_core.sv]
// ----------------------------------------------------------------------------
// uer_core: ranging sequencer
// Holds the measurement phase and tick counter, advances them by one tick per
// enabled cycle and forms the result for that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                tick_en,
    input  wire                                action,
    input  wire                                echo_level,
    input  wire  [uer_pkg::TIMEOUT_W-1:0]      timeout_us,
    input  wire  [uer_pkg::DIST_W-1:0]         max_distance_cm,
    output uer_pkg::res_t                      res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PRELOW = 3'd1,
        PH_TRIGHI = 3'd2,
        PH_WAIT   = 3'd3,
        PH_MEAS   = 3'd4
    } phase_t;

    phase_t                       phase_reg, phase_next, phase_eff;
    logic [uer_pkg::COUNT_W-1:0]  count_reg, count_next, count_eff, count_inc;
    logic [uer_pkg::COUNT_W-1:0]  timeout_ext;
    logic [31:0]                  cm_prod;
    logic [uer_pkg::QUOT_W-1:0]   cm_quot;
    logic                         start;

    assign timeout_ext = {1'b0, timeout_us};
    assign start       = (phase_reg == PH_IDLE) && action;
    assign phase_eff   = start ? PH_PRELOW : phase_reg;
    assign count_eff   = start ? '0 : count_reg;
    assign count_inc   = count_eff + uer_pkg::COUNT_W'(1);

    // Width in ticks to centimetres; the count never reaches 2^17 so the
    // halved operand fits 16 bits.
    assign cm_prod = count_reg[uer_pkg::COUNT_W-1:1] * 16'(uer_pkg::CM_RECIP);
    assign cm_quot = cm_prod[uer_pkg::RECIP_SHIFT +: uer_pkg::QUOT_W];

    always_comb begin
        phase_next      = phase_eff;
        count_next      = count_eff;
        res             = '0;
        res.status      = uer_pkg::ST_NONE;
        unique case (phase_eff)
            PH_IDLE: begin
            end
            PH_PRELOW: begin
                count_next = count_inc;
                if (count_inc >= uer_pkg::COUNT_W'(uer_pkg::PRE_LOW_TICKS)) begin
                    phase_next = PH_TRIGHI;
                    count_next = '0;
                end
            end
            PH_TRIGHI: begin
                res.trigger_level = 1'b1;
                count_next        = count_inc;
                if (count_inc >= uer_pkg::COUNT_W'(uer_pkg::TRIGGER_HIGH_TICKS)) begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
            end
            PH_WAIT: begin
                if (echo_level) begin
                    phase_next = PH_MEAS;
                    count_next = uer_pkg::COUNT_W'(1);
                    if (timeout_us == '0) begin
                        res.done   = 1'b1;
                        res.status = uer_pkg::ST_TOOLONG;
                    end
                end else begin
                    count_next = count_inc;
                    if (count_inc > timeout_ext) begin
                        res.done   = 1'b1;
                        res.status = uer_pkg::ST_NORISE;
                    end
                end
            end
            PH_MEAS: begin
                if (echo_level) begin
                    count_next = count_inc;
                    if (count_inc > timeout_ext) begin
                        res.done   = 1'b1;
                        res.status = uer_pkg::ST_TOOLONG;
                    end
                end else begin
                    res.done = 1'b1;
                    if (cm_quot > {1'b0, max_distance_cm}) begin
                        res.status = uer_pkg::ST_RANGE;
                    end else begin
                        res.status      = uer_pkg::ST_VALID;
                        res.distance_cm = cm_quot[uer_pkg::DIST_W-1:0];
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
        if (res.done) begin
            phase_next = PH_IDLE;
            count_next = '0;
        end
        res.busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end else if (tick_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ultrasonic_echo_ranger.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: trigger/echo ranging controller, one beat per tick
//
// Each input beat on s_ is one microsecond tick carrying a start request
// (s_action) and the sampled echo pin (s_echo_level). Each accepted beat
// yields exactly one result beat on m_ with the trigger pin level for that
// tick, the busy and done flags, a status code and the distance in cm.
// Input beats are captured in an input register; the sequencer and the
// reciprocal-multiply distance conversion sit between it and the result
// register, which captures each result beat as its input beat moves on.
// Throughput is one beat per cycle: a new beat is taken whenever the input
// register is empty or will move on in the same cycle, including while a
// result is still waiting to be taken.
// When m_ready is low the result register holds, the input register fills,
// and s_ready drops until the receiver takes the waiting result.
// Configuration writes (cfg_index 0: timeout_us, 1: max_distance_cm; other
// indexes are ignored) are always accepted and should only be issued while
// no measurement beat is in flight.
// Synchronous active-low reset empties both registers, returns the sequencer
// to idle and loads timeout_us = 30000 and max_distance_cm = 400.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input tick channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_action,
    input  wire                              s_echo_level,
    // result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_trigger_level,
    output logic                             m_busy_res,
    output logic                             m_done_res,
    output logic [2:0]                       m_status,
    output logic [uer_pkg::DIST_W-1:0]       m_distance_cm,
    // configuration write channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [uer_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                          in_valid_reg;
    logic                          in_action_reg;
    logic                          in_echo_reg;
    logic                          out_valid_reg;
    uer_pkg::res_t                 res_reg;
    uer_pkg::res_t                 core_res;
    logic [uer_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [uer_pkg::DIST_W-1:0]    max_dist_reg;
    logic                          out_free;
    logic                          advance;

    // The result register can take a new value when it is empty or its
    // current beat is leaving; the input register then moves on.
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    uer_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick_en         (advance),
        .action          (in_action_reg),
        .echo_level      (in_echo_reg),
        .timeout_us      (timeout_reg),
        .max_distance_cm (max_dist_reg),
        .res             (core_res)
    );

    // Control state: stage occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_echo_reg   <= s_echo_level;
        end
        if (advance) begin
            res_reg <= core_res;
        end
    end

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= uer_pkg::TIMEOUT_RESET;
            max_dist_reg <= uer_pkg::MAX_DIST_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                uer_pkg::REG_TIMEOUT: begin
                    timeout_reg <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
                end
                uer_pkg::REG_MAX_DIST: begin
                    max_dist_reg <= cfg_data[uer_pkg::DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_trigger_level = res_reg.trigger_level;
    assign m_busy_res      = res_reg.busy;
    assign m_done_res      = res_reg.done;
    assign m_status        = res_reg.status;
    assign m_distance_cm   = res_reg.distance_cm;

endmodule

`default_nettype wire

[tb/ultrasonic_echo_ranger_tb.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb: self-checking bench for the echo ranger
// Feeds microsecond tick beats carrying start requests and echo levels,
// predicts every result beat from an internal copy of the ranging sequencer,
// and compares each beat field by field as it leaves the block. The run walks
// through several register settings, from a zero timeout up to the reset
// value of 30000 ticks, under three patterns of back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_tb;

    // Sequencer phases as the predictor tracks them.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PRELOW = 3'd1,
        PH_TRIGHI = 3'd2,
        PH_WAIT   = 3'd3,
        PH_MEAS   = 3'd4
    } phase_t;

    // Register indexes that the block must ignore.
    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Generous cap on the whole run, in time units (two per clock cycle).
    localparam int unsigned RUN_LIMIT = 3_000_000;

    // ------------------------------------------------------------------------
    // Ranging predictor and the queue of result beats it expects.
    // ------------------------------------------------------------------------
    class ranging_scoreboard;
        logic [uer_pkg::TIMEOUT_W-1:0] timeout;
        logic [uer_pkg::DIST_W-1:0]    max_dist;
        phase_t                        phase;
        logic [uer_pkg::COUNT_W-1:0]   count;
        uer_pkg::res_t                 pending_results[$];
        int                            errors;
        int                            ticks;
        int                            checked;
        int                            outcomes[5];

        function new();
            timeout  = uer_pkg::TIMEOUT_RESET;
            max_dist = uer_pkg::MAX_DIST_RESET;
            phase    = PH_IDLE;
            count    = '0;
            errors   = 0;
            ticks    = 0;
            checked  = 0;
            foreach (outcomes[i]) outcomes[i] = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        function void write_reg(logic [uer_pkg::CFG_IDX_W-1:0] idx,
                                logic [uer_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                uer_pkg::REG_TIMEOUT:  timeout  = data[uer_pkg::TIMEOUT_W-1:0];
                uer_pkg::REG_MAX_DIST: max_dist = data[uer_pkg::DIST_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the sequencer by one accepted tick and queue its result.
        function void note_tick(logic act, logic echo);
            uer_pkg::res_t r;
            int unsigned   cm;
            r = '0;
            r.status = uer_pkg::ST_NONE;
            if (phase == PH_IDLE && act) begin
                phase = PH_PRELOW;
                count = '0;
            end
            case (phase)
                PH_PRELOW: begin
                    count = count + 1'b1;
                    if (count >= uer_pkg::PRE_LOW_TICKS) begin
                        phase = PH_TRIGHI;
                        count = '0;
                    end
                end
                PH_TRIGHI: begin
                    r.trigger_level = 1'b1;
                    count = count + 1'b1;
                    if (count >= uer_pkg::TRIGGER_HIGH_TICKS) begin
                        phase = PH_WAIT;
                        count = '0;
                    end
                end
                PH_WAIT: begin
                    if (echo) begin
                        // The rise tick already counts as one tick of width.
                        phase = PH_MEAS;
                        count = uer_pkg::COUNT_W'(1);
                        if (count > timeout) begin
                            r.done   = 1'b1;
                            r.status = uer_pkg::ST_TOOLONG;
                        end
                    end else begin
                        count = count + 1'b1;
                        if (count > timeout) begin
                            r.done   = 1'b1;
                            r.status = uer_pkg::ST_NORISE;
                        end
                    end
                end
                PH_MEAS: begin
                    if (echo) begin
                        count = count + 1'b1;
                        if (count > timeout) begin
                            r.done   = 1'b1;
                            r.status = uer_pkg::ST_TOOLONG;
                        end
                    end else begin
                        cm = count / uer_pkg::CM_DIVISOR;
                        r.done = 1'b1;
                        if (cm > max_dist) begin
                            r.status = uer_pkg::ST_RANGE;
                        end else begin
                            r.status      = uer_pkg::ST_VALID;
                            r.distance_cm = cm[uer_pkg::DIST_W-1:0];
                        end
                    end
                end
                default: phase = PH_IDLE;
            endcase
            if (r.done) begin
                phase = PH_IDLE;
                count = '0;
                outcomes[r.status]++;
            end
            r.busy = (phase != PH_IDLE);
            pending_results.push_back(r);
            ticks++;
        endfunction

        task check_result(logic trig, logic busy, logic done, logic [2:0] status,
                          logic [uer_pkg::DIST_W-1:0] dist_cm);
            uer_pkg::res_t want;
            if (pending_results.size() == 0) begin
                report("result beat arrived with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (trig !== want.trigger_level)
                report($sformatf("beat %0d trigger %b, expected %b", checked, trig,
                                 want.trigger_level));
            if (busy !== want.busy)
                report($sformatf("beat %0d busy %b, expected %b", checked, busy, want.busy));
            if (done !== want.done)
                report($sformatf("beat %0d done %b, expected %b", checked, done, want.done));
            if (status !== want.status)
                report($sformatf("beat %0d status %0d, expected %0d", checked, status,
                                 want.status));
            if (dist_cm !== want.distance_cm)
                report($sformatf("beat %0d distance %0d, expected %0d", checked, dist_cm,
                                 want.distance_cm));
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known level so nothing floats while reset is held.
    // ------------------------------------------------------------------------
    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           s_valid      = 1'b0;
    logic                           s_action     = 1'b0;
    logic                           s_echo_level = 1'b0;
    logic                           m_ready      = 1'b0;
    logic                           cfg_valid    = 1'b0;
    logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    wire                            s_ready;
    wire                            m_valid;
    wire                            m_trigger_level;
    wire                            m_busy_res;
    wire                            m_done_res;
    wire  [2:0]                     m_status;
    wire  [uer_pkg::DIST_W-1:0]     m_distance_cm;
    wire                            cfg_ready;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ultrasonic_echo_ranger dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_echo_level    (s_echo_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger_level (m_trigger_level),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_status        (m_status),
        .m_distance_cm   (m_distance_cm),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    ranging_scoreboard sb = new();

    // Percentages of cycles in which the sender holds back a beat and the
    // receiver refuses one. The main sequence changes them between stages.
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 85;
    int          settings_used = 1;

    // ------------------------------------------------------------------------
    // Result sink. Signals are read in the active region right after the
    // edge, so they still hold the values that the edge itself saw; a beat
    // counts as taken when valid and ready were both high at that edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_trigger_level, m_busy_res, m_done_res, m_status,
                                m_distance_cm);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // Offer one tick beat and return at the edge that accepts it. Valid is
    // only lowered when an idle cycle is actually inserted, so back-to-back
    // beats keep it high without a glitch within one time step.
    task automatic send_tick(input logic act, input logic echo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_echo_level <= echo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(act, echo);
    endtask

    // One well-formed measurement: a start beat, the trigger pulse, `gap`
    // ticks of low echo, then `width` ticks of high echo and a falling tick.
    // Each stage stops early once the predictor says the measurement ended,
    // so timeouts end the sequence cleanly. Start requests during the pulse
    // are random and must be ignored by the block.
    task automatic measure(input int gap, input int width);
        int n;
        send_tick(1'b1, coin());
        while (sb.phase == PH_PRELOW || sb.phase == PH_TRIGHI)
            send_tick(coin(), coin());
        n = 0;
        while (sb.phase == PH_WAIT && n < gap) begin
            send_tick(coin(), 1'b0);
            n++;
        end
        n = 0;
        while (sb.phase != PH_IDLE && n < width) begin
            send_tick(coin(), 1'b1);
            n++;
        end
        if (sb.phase != PH_IDLE)
            send_tick(coin(), 1'b0);
    endtask

    // Bring the sequencer back to idle, stop offering beats and wait until
    // every expected result has been taken. A waiting sequencer is given a
    // rise and then a fall so that its measurement ends.
    task automatic quiesce();
        while (sb.phase != PH_IDLE)
            send_tick(1'b0, sb.phase == PH_WAIT);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Keeps cfg_valid high; whoever issues a group of writes lowers it.
    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic [uer_pkg::CFG_DATA_W-1:0] tmo,
                                 input logic [uer_pkg::CFG_DATA_W-1:0] max_cm);
        quiesce();
        write_reg(uer_pkg::REG_TIMEOUT, tmo);
        write_reg(uer_pkg::REG_MAX_DIST, max_cm);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random traffic for roughly `budget` ticks. Most of it is complete
    // measurements with random gaps and widths reaching past the timeout,
    // so every ending is hit; the rest is loose ticks with random start
    // requests and echo levels.
    task automatic random_phase(input int budget);
        int first;
        int tmo;
        int gap;
        int width;
        first = sb.ticks;
        tmo   = sb.timeout;
        while (sb.ticks - first < budget) begin
            if ($urandom_range(99) < 75) begin
                gap   = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(tmo + 3);
                width = ($urandom_range(99) < 40) ? $urandom_range(4) : $urandom_range(tmo + 3);
                measure(gap, width);
            end else begin
                repeat ($urandom_range(5, 1)) send_tick(coin(), coin());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings. Idle ticks, with the echo high too, give plain
        // results. A rise on the very first waiting tick with a width of one
        // gives distance zero; widths of 57 and 58 check the division.
        // Each measurement starts on the tick right after the previous one
        // finished.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        measure(0, 1);
        measure(3, 57);
        measure(0, 58);
        send_tick(1'b0, 1'b0);

        // A zero timeout: the rise tick alone is already too long, and a
        // single low tick is already a missing echo.
        apply_setting(16'd0, 16'd0);
        measure(0, 1);
        measure(1, 1);
        random_phase(40);

        apply_setting(16'd70, 16'd0);
        random_phase(90);

        // Swap the back-pressure pattern. Writes to the spare indexes must
        // leave both registers alone.
        send_idle_pct = 85;
        recv_idle_pct = 27;
        quiesce();
        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
        apply_setting(16'd130, 16'd1);
        random_phase(90);

        // Timeout of one, and a limit written with all ones so only the
        // low eleven bits survive.
        apply_setting(16'd1, 16'hFFFF);
        measure(1, 1);
        measure(0, 2);
        measure(2, 0);
        random_phase(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(16'd40, 16'd0);
        random_phase(90);

        // Timeout of sixty with a limit of 1130 (the write carries
        // junk above bit ten). The widest echo allowed gives 1 cm, one tick
        // more is too long, and the longest wait runs into a missing echo.
        // A limit whose low eleven bits are all zero turns the same echo out
        // of range.
        apply_setting(16'd60, 16'hFC6A);
        measure(0, 60);
        measure(0, 61);
        measure(61, 1);
        apply_setting(16'd60, 16'hF800);
        measure(0, 60);

        quiesce();
        repeat (8) @(posedge aclk);

        $display("checked %0d result beats over %0d register settings",
                 sb.checked, settings_used);
        $display("finished measurements: %0d valid, %0d no rise, %0d too long, %0d out of range",
                 sb.outcomes[uer_pkg::ST_VALID], sb.outcomes[uer_pkg::ST_NORISE],
                 sb.outcomes[uer_pkg::ST_TOOLONG], sb.outcomes[uer_pkg::ST_RANGE]);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT);
        $display("timeout: %0d results still expected", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/uer_pkg.sv
rtl/uer_core.sv
rtl/ultrasonic_echo_ranger.sv
tb/ultrasonic_echo_ranger_tb.sv
